// File: src/sprite_screen_projection_defines.svh
// Assertion macros for the sprite screen projection block.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef SPRITE_SCREEN_PROJECTION_DEFINES_SVH
`define SPRITE_SCREEN_PROJECTION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssp assertion failed");
// Next-cycle implication.
`define SSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssp assertion failed");
`else
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/ssp_pkg.sv
// Shared types, constants and saturation helpers for the sprite projection block.
// No dependencies.
package ssp_pkg;

  localparam int DIR_FRAC = 14;
  localparam int CFG_W    = 13;
  localparam int DIV_DW   = 56;
  localparam int DIV_VW   = 32;
  localparam int DIV_CW   = $clog2(DIV_DW + 1);

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE  = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
    logic [15:0]      height_scale;
  } ssp_cfg_t;

  typedef struct packed {
    logic signed [41:0] num_lat;
    logic signed [41:0] num_dep;
    logic signed [32:0] det;
  } ssp_job_t;

  typedef struct packed {
    logic signed [27:0] depth;
    logic signed [15:0] center_column;
    logic [15:0]        sprite_size;
    logic [14:0]        start_column;
    logic signed [15:0] end_column;
    logic [11:0]        start_row;
    logic [11:0]        end_row;
    logic               invalid;
  } ssp_result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_SAT, ST_MUL, ST_START2, ST_DIV2, ST_SCALE, ST_SIZE, ST_FIN
  } ssp_state_e;

  function automatic logic signed [27:0] sat28(input logic neg,
                                               input logic [DIV_DW-1:0] mag);
    logic signed [27:0] r;
    if (neg) begin
      if (mag > DIV_DW'(134217728)) r = 28'sh8000000;
      else r = -$signed(mag[27:0]);
    end else begin
      if (mag > DIV_DW'(134217727)) r = 28'sh7FFFFFF;
      else r = $signed(mag[27:0]);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic neg,
                                               input logic [DIV_DW-1:0] mag);
    logic signed [15:0] r;
    if (neg) begin
      if (mag > DIV_DW'(32768)) r = 16'sh8000;
      else r = -$signed(mag[15:0]);
    end else begin
      if (mag > DIV_DW'(32767)) r = 16'sh7FFF;
      else r = $signed(mag[15:0]);
    end
    return r;
  endfunction

endpackage

// File: src/sprite_screen_projection.sv
// Channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// input     | in_valid_i / in_stall_o     | sprite, player, dir and plane fields
// output    | out_valid_o / out_stall_i   | depth, centre, size, bounds, invalid
// config    | psel/penable/pwrite, pready | screen_width, screen_height, height_scale
//
// The front end takes a beat every cycle while the two-entry job queue has room.
// The back end works on one item at a time with two serial 56-bit dividers
// run twice (lateral and depth, then centre and base size), one bit a cycle;
// a zero determinant skips both division phases and a zero depth the second.
// Reset clears handshake state and loads 640 x 480 with unit scale; no clearing pass.
// A stalled output holds its beat while further items queue up behind it.
// Top level of the sprite screen projection block.
// Depends on ssp_pkg, ssp_front, ssp_fifo, ssp_back and the defines header.
`include "sprite_screen_projection_defines.svh"
module sprite_screen_projection import ssp_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        sprite_x_i,
  input  logic [23:0]        sprite_y_i,
  input  logic [23:0]        player_x_i,
  input  logic [23:0]        player_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] plane_x_i,
  input  logic signed [15:0] plane_y_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [27:0] depth_o,
  output logic signed [15:0] center_column_o,
  output logic [15:0]        sprite_size_o,
  output logic [14:0]        start_column_o,
  output logic signed [15:0] end_column_o,
  output logic [11:0]        start_row_o,
  output logic [11:0]        end_row_o,
  output logic               invalid_o
);

  ssp_cfg_t    cfg_q;
  logic        cfg_wr;
  ssp_job_t    push_job, pop_job;
  logic        q_push, q_pop, q_full, q_empty;
  ssp_result_t res;

  // Register file: writes land in the access phase, pready is always high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= CFG_W'(640);
      cfg_q.screen_height <= CFG_W'(480);
      cfg_q.height_scale  <= 16'd256;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[CFG_W-1:0];
        REG_HEIGHT_SCALE:  cfg_q.height_scale  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCREEN_WIDTH:  prdata = 32'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
      REG_HEIGHT_SCALE:  prdata = 32'(cfg_q.height_scale);
      default:           prdata = '0;
    endcase
  end

  // Front: offsets and camera products
  ssp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sprite_x_i, .sprite_y_i, .player_x_i, .player_y_i,
    .dir_x_i, .dir_y_i, .plane_x_i, .plane_y_i,
    .full_i(q_full), .push_o(q_push), .job_o(push_job)
  );

  // Decouple the fixed-rate front from the iterative back
  ssp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(push_job), .pop_i(q_pop),
    .data_o(pop_job), .full_o(q_full), .empty_o(q_empty)
  );

  // Back: divisions, saturation, scaling and clamps
  ssp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .job_i(pop_job), .empty_i(q_empty),
    .pop_o(q_pop), .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign depth_o         = res.depth;
  assign center_column_o = res.center_column;
  assign sprite_size_o   = res.sprite_size;
  assign start_column_o  = res.start_column;
  assign end_column_o    = res.end_column;
  assign start_row_o     = res.start_row;
  assign end_row_o       = res.end_row;
  assign invalid_o       = res.invalid;

  // Input stalls only ever come from a full queue
  `SSP_ASSERT_IMP(a_stall_from_full, clk_i, rst_ni, in_stall_o, q_full)
  // The back end never pops an empty queue
  `SSP_ASSERT_IMP(a_pop_has_data, clk_i, rst_ni, q_pop, !q_empty)
  // An invalid beat carries zero depth and size
  `SSP_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_o && invalid_o, (depth_o == '0) && (sprite_size_o == '0))
  // A width write takes effect on the next edge
  `SSP_ASSERT_NXT(a_width_write, clk_i, rst_ni, cfg_wr && (paddr[3:2] == REG_SCREEN_WIDTH), cfg_q.screen_width == $past(pwdata[CFG_W-1:0]))

endmodule

// File: src/ssp_front.sv
// Front end: accept a beat, form the offsets and the six camera products.
// Depends on ssp_pkg.
module ssp_front import ssp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        sprite_x_i,
  input  logic [23:0]        sprite_y_i,
  input  logic [23:0]        player_x_i,
  input  logic [23:0]        player_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] plane_x_i,
  input  logic signed [15:0] plane_y_i,
  input  logic               full_i,
  output logic               push_o,
  output ssp_job_t           job_o
);

  logic               valid_q;
  logic               advance;
  logic signed [24:0] dx, dy;
  logic signed [40:0] dyx_q, dxy_q, pxy_q, pyx_q;
  logic signed [31:0] pxdy_q, dxpy_q;

  assign dx = $signed({1'b0, sprite_x_i}) - $signed({1'b0, player_x_i});
  assign dy = $signed({1'b0, sprite_y_i}) - $signed({1'b0, player_y_i});

  assign advance    = !valid_q || !full_i;
  assign in_stall_o = valid_q && full_i;
  assign push_o     = valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      dyx_q  <= dir_y_i * dx;
      dxy_q  <= dir_x_i * dy;
      pxy_q  <= plane_x_i * dy;
      pyx_q  <= plane_y_i * dx;
      pxdy_q <= plane_x_i * dir_y_i;
      dxpy_q <= dir_x_i * plane_y_i;
    end
  end

  always_comb begin
    job_o.num_lat = 42'(dyx_q) - 42'(dxy_q);
    job_o.num_dep = 42'(pxy_q) - 42'(pyx_q);
    job_o.det     = 33'(pxdy_q) - 33'(dxpy_q);
  end

endmodule

// File: src/ssp_fifo.sv
// Two-entry queue of jobs between the front end and the back end.
// Depends on ssp_pkg.
module ssp_fifo import ssp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ssp_job_t data_i,
  input  logic     pop_i,
  output ssp_job_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  ssp_job_t   mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_ptr_q] <= data_i;
  end

endmodule

// File: src/ssp_div.sv
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on ssp_pkg.
module ssp_div import ssp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [DIV_VW-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_DW-1:0] quotient_o
);

  logic [DIV_DW-1:0] quo_q;
  logic [DIV_VW-1:0] rem_q, div_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              done_q;
  logic [DIV_VW:0]   rem_sh, rem_sub;
  logic              bit_ok;

  assign rem_sh  = {rem_q, quo_q[DIV_DW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign bit_ok  = (rem_sh >= {1'b0, div_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CW'(DIV_DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_DW-2:0], bit_ok};
      rem_q <= bit_ok ? rem_sub[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
    end
  end

endmodule

// File: src/ssp_back.sv
// Back end: sequence the divisions, saturate, scale and clamp into the result register.
// Depends on ssp_pkg and ssp_div.
module ssp_back import ssp_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ssp_cfg_t    cfg_i,
  input  ssp_job_t    job_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ssp_result_t res_o
);

  localparam int BASE_W = CFG_W + FRAC_BITS;

  ssp_state_e state_q, state_d;

  logic                div_start, div_done_a, div_done_b;
  logic [DIV_DW-1:0]   dvd_a, dvd_b, quo_a, quo_b;
  logic [DIV_VW-1:0]   dvs;
  logic                load_out, out_free;

  logic                lat_neg_q, dep_neg_q, inv_q;
  logic signed [27:0]  lat_q, dep_q;
  logic signed [41:0]  prod_q;
  logic signed [15:0]  ccol_q;
  logic [BASE_W-1:0]   base_q;
  logic [15:0]         size_q;
  logic                out_valid_q;
  ssp_result_t         res_q, res_d;

  logic [41:0]         mag_lat, mag_dep, mag_prod;
  logic [32:0]         mag_det;
  logic [27:0]         mag_dep_q;
  logic [BASE_W+15:0]  size_prod;
  logic [BASE_W+7:0]   size_shr;

  logic [14:0]         half_sz;
  logic signed [17:0]  hsz_s, hh_s, h_s, w_s, ccol_s;
  logic signed [17:0]  srow_w, erow_w, scol_w, ecol_w;

  // Magnitudes for the two division phases
  assign mag_lat   = job_i.num_lat[41] ? 42'(-job_i.num_lat) : 42'(job_i.num_lat);
  assign mag_dep   = job_i.num_dep[41] ? 42'(-job_i.num_dep) : 42'(job_i.num_dep);
  assign mag_det   = job_i.det[32] ? 33'(-job_i.det) : 33'(job_i.det);
  assign mag_prod  = prod_q[41] ? 42'(-prod_q) : 42'(prod_q);
  assign mag_dep_q = dep_q[27] ? 28'(-dep_q) : 28'(dep_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!empty_i) state_d = (job_i.det == '0) ? ST_FIN : ST_DIV1;
      ST_DIV1:   if (div_done_a && div_done_b) state_d = ST_SAT;
      ST_SAT:    state_d = ST_MUL;
      ST_MUL:    state_d = (dep_q == '0) ? ST_FIN : ST_START2;
      ST_START2: state_d = ST_DIV2;
      ST_DIV2:   if (div_done_a && div_done_b) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_SIZE;
      ST_SIZE:   state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    dvd_a     = {mag_lat, DIR_FRAC'(0)};
    dvd_b     = {mag_dep, DIR_FRAC'(0)};
    dvs       = mag_det[DIV_VW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        pop_o     = !empty_i;
        div_start = !empty_i && (job_i.det != '0);
      end
      ST_START2: begin
        div_start = 1'b1;
        dvd_a     = DIV_DW'(mag_prod);
        dvd_b     = DIV_DW'(cfg_i.screen_height) << FRAC_BITS;
        dvs       = DIV_VW'(mag_dep_q);
      end
      ST_FIN: load_out = out_free;
      default: ;
    endcase
  end

  ssp_div u_div_a (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_a), .divisor_i(dvs),
    .done_o(div_done_a), .quotient_o(quo_a)
  );

  ssp_div u_div_b (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dvd_b), .divisor_i(dvs),
    .done_o(div_done_b), .quotient_o(quo_b)
  );

  assign size_prod = base_q * cfg_i.height_scale;
  assign size_shr  = size_prod[BASE_W+15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (!empty_i) begin
        lat_neg_q <= job_i.num_lat[41] ^ job_i.det[32];
        dep_neg_q <= job_i.num_dep[41] ^ job_i.det[32];
        inv_q     <= (job_i.det == '0);
      end
      ST_SAT: begin
        lat_q <= sat28(lat_neg_q, quo_a);
        dep_q <= sat28(dep_neg_q, quo_b);
      end
      ST_MUL: begin
        prod_q <= $signed({1'b0, cfg_i.screen_width[CFG_W-1:1]}) * (29'(dep_q) + 29'(lat_q));
        inv_q  <= (dep_q == '0);
      end
      ST_SCALE: begin
        ccol_q <= sat16(prod_q[41] ^ dep_q[27], quo_a);
        base_q <= quo_b[BASE_W-1:0];
      end
      ST_SIZE: size_q <= (size_shr > (BASE_W+8)'(65535)) ? 16'hFFFF : size_shr[15:0];
      default: ;
    endcase
    if (load_out) res_q <= res_d;
  end

  // Draw bounds from the registered size and centre
  always_comb begin
    half_sz = size_q[15:1];
    hsz_s   = $signed(18'(half_sz));
    hh_s    = $signed(18'(cfg_i.screen_height[CFG_W-1:1]));
    h_s     = $signed(18'(cfg_i.screen_height));
    w_s     = $signed(18'(cfg_i.screen_width));
    ccol_s  = 18'(ccol_q);

    srow_w = hh_s - hsz_s;
    if (srow_w < 0) srow_w = '0;
    erow_w = hsz_s + hh_s;
    if (erow_w >= h_s) erow_w = h_s - 18'sd1;
    if (erow_w < 0) erow_w = '0;
    else if (erow_w > 18'sd4095) erow_w = 18'sd4095;

    scol_w = ccol_s - hsz_s;
    if (scol_w < 0) scol_w = '0;
    ecol_w = hsz_s + ccol_s;
    if (ecol_w >= w_s) ecol_w = w_s - 18'sd1;
    if (ecol_w > 18'sd4095) ecol_w = 18'sd4095;

    res_d = '0;
    if (inv_q) begin
      res_d.invalid = 1'b1;
    end else begin
      res_d.depth         = dep_q;
      res_d.center_column = ccol_q;
      res_d.sprite_size   = size_q;
      res_d.start_column  = scol_w[14:0];
      res_d.end_column    = ecol_w[15:0];
      res_d.start_row     = srow_w[11:0];
      res_d.end_row       = erow_w[11:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: tb/tb_sprite_screen_projection.sv
// Self-checking testbench for sprite_screen_projection: random and directed sprite beats,
// an in-bench projection predictor and an ordered result scoreboard.
// Depends on ssp_pkg and the sprite_screen_projection RTL.
module tb_sprite_screen_projection;
  import ssp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as the bench sees it.
  typedef struct packed {
    logic [23:0]        sprite_x;
    logic [23:0]        sprite_y;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } sprite_beat_t;

  localparam int PHASE_ITEMS   = 250;
  localparam int DRAIN_CYCLES  = 200;
  localparam int WATCHDOG_MAX  = 20000; // several times the slowest beat plus a long stall

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  sprite_beat_t drv;
  ssp_result_t got;

  // Shadow copy of the projection registers.
  logic [12:0] width_q, height_q;
  logic [15:0] scale_q;

  sprite_beat_t pending_q[$];
  ssp_result_t  projection_q[$];
  int errors, mismatches, beats_in, beats_out, invalid_seen, idle_cycles;
  int send_gap, stall_left;
  bit steady; // no idling on either side during this phase

  sprite_screen_projection u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sprite_x_i(drv.sprite_x), .sprite_y_i(drv.sprite_y),
    .player_x_i(drv.player_x), .player_y_i(drv.player_y),
    .dir_x_i(drv.dir_x), .dir_y_i(drv.dir_y),
    .plane_x_i(drv.plane_x), .plane_y_i(drv.plane_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .depth_o(got.depth), .center_column_o(got.center_column),
    .sprite_size_o(got.sprite_size), .start_column_o(got.start_column),
    .end_column_o(got.end_column), .start_row_o(got.start_row),
    .end_row_o(got.end_row), .invalid_o(got.invalid)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Project one sprite into screen space with the current register values.
  // Every division truncates toward zero, as longint division does.
  function automatic ssp_result_t project_sprite(sprite_beat_t b);
    longint dx, dy, dirx, diry, plx, ply, det, lat, dep, w, h;
    longint ccol, base, size, half_sz, srow, erow, scol, ecol;
    ssp_result_t r;
    r = '0;
    dx = longint'(b.sprite_x) - longint'(b.player_x);
    dy = longint'(b.sprite_y) - longint'(b.player_y);
    dirx = longint'(b.dir_x);
    diry = longint'(b.dir_y);
    plx = longint'(b.plane_x);
    ply = longint'(b.plane_y);
    w = longint'(width_q);
    h = longint'(height_q);
    det = plx * diry - dirx * ply;
    if (det == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    lat = clip((diry * dx - dirx * dy) * (64'sd1 <<< DIR_FRAC) / det, -134217728, 134217727);
    dep = clip((plx * dy - ply * dx) * (64'sd1 <<< DIR_FRAC) / det, -134217728, 134217727);
    if (dep == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    ccol = clip((w / 2) * (dep + lat) / dep, -32768, 32767);
    base = h * 4096 / dep;
    if (base < 0) base = -base;
    size = base * longint'(scale_q) / 256;
    if (size > 65535) size = 65535;
    half_sz = size / 2;
    srow = h / 2 - half_sz;
    if (srow < 0) srow = 0;
    erow = half_sz + h / 2;
    if (erow >= h) erow = h - 1;
    erow = clip(erow, 0, 4095);
    scol = ccol - half_sz;
    if (scol < 0) scol = 0;
    ecol = half_sz + ccol;
    if (ecol >= w) ecol = w - 1;
    ecol = clip(ecol, -32768, 4095);
    r.depth = dep[27:0];
    r.center_column = ccol[15:0];
    r.sprite_size = size[15:0];
    r.start_column = scol[14:0];
    r.end_column = ecol[15:0];
    r.start_row = srow[11:0];
    r.end_row = erow[11:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a steady phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: hold the payload while stalled, advance on acceptance, insert gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        projection_q.push_back(project_sprite(drv));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_q.size() > 0) begin
          drv <= pending_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, then check each accepted result beat in order.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (got.invalid) invalid_seen <= invalid_seen + 1;
        if (projection_q.size() == 0) begin
          errors <= errors + 1;
          $display("unexpected result beat at %0t", $realtime);
        end else begin : check_beat
          ssp_result_t want;
          want = projection_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"mismatch beat %0d: dep %h/%h ccol %h/%h size %h/%h scol %h/%h ",
                        "ecol %h/%h srow %h/%h erow %h/%h inv %b/%b"}, beats_out,
                       want.depth, got.depth, want.center_column, got.center_column,
                       want.sprite_size, got.sprite_size, want.start_column,
                       got.start_column, want.end_column, got.end_column,
                       want.start_row, got.start_row, want.end_row, got.end_row,
                       want.invalid, got.invalid);
          end
        end
      end
      // Watchdog: count cycles with work outstanding and no beat moving.
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_q.size() == 0 && projection_q.size() == 0 && !in_valid))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  width_q = value[12:0];
      REG_SCREEN_HEIGHT: height_q = value[12:0];
      REG_HEIGHT_SCALE:  scale_q = value[15:0];
      default: ;
    endcase
  endtask

  // Plausible view: unit-ish direction, perpendicular plane, sprite near the player.
  function automatic sprite_beat_t scene_beat();
    sprite_beat_t b;
    int dxv, dyv;
    dxv = $urandom_range(0, 32767) - 16384;
    dyv = $urandom_range(0, 32767) - 16384;
    b.dir_x = 16'(dxv);
    b.dir_y = 16'(dyv);
    b.plane_x = 16'(-(dyv * 2) / 3);
    b.plane_y = 16'((dxv * 2) / 3);
    b.player_x = 24'($urandom_range(64 << 12, 4000 << 12));
    b.player_y = 24'($urandom_range(64 << 12, 4000 << 12));
    b.sprite_x = 24'(b.player_x + $urandom_range(0, 2 * (12 << 12)) - (12 << 12));
    b.sprite_y = 24'(b.player_y + $urandom_range(0, 2 * (12 << 12)) - (12 << 12));
    return b;
  endfunction

  function automatic sprite_beat_t noise_beat();
    sprite_beat_t b;
    b.sprite_x = 24'($urandom);
    b.sprite_y = 24'($urandom);
    b.player_x = 24'($urandom);
    b.player_y = 24'($urandom);
    b.dir_x = 16'($urandom);
    b.dir_y = 16'($urandom);
    b.plane_x = 16'($urandom);
    b.plane_y = 16'($urandom);
    return b;
  endfunction

  task automatic queue_directed();
    sprite_beat_t b;
    // Zero determinant: all-zero view vectors, then parallel direction and plane.
    b = '0;
    pending_q.push_back(b);
    b = scene_beat();
    b.plane_x = b.dir_x;
    b.plane_y = b.dir_y;
    pending_q.push_back(b);
    // Zero depth: sprite on top of the player.
    b = scene_beat();
    b.sprite_x = b.player_x;
    b.sprite_y = b.player_y;
    pending_q.push_back(b);
    // Sprite straight ahead, behind, barely ahead, and just beside the view axis.
    b = '{24'h101000, 24'h100000, 24'h100000, 24'h100000, 16'sh4000, 16'sh0000,
          16'sh0000, 16'shD5C3};
    pending_q.push_back(b);
    b.sprite_x = 24'h0FF000;
    pending_q.push_back(b);
    b.sprite_x = 24'h100001;
    pending_q.push_back(b);
    b.sprite_x = 24'h110000;
    b.sprite_y = 24'h100800;
    pending_q.push_back(b);
    // Field extremes: far corners of the map and extreme vectors.
    b = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000, 16'sh7FFF, 16'sh8000,
          16'sh0001, 16'sh0000};
    pending_q.push_back(b);
    b = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 16'sh8000, 16'sh7FFF,
          16'sh7FFF, 16'sh8000};
    pending_q.push_back(b);
    b = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 16'sh0001, 16'sh0000,
          16'sh0000, 16'shFFFF};
    pending_q.push_back(b);
    b = '{24'h000001, 24'hFFFFFE, 24'h800000, 24'h7FFFFF, 16'shFFFF, 16'sh0001,
          16'sh8000, 16'sh8000};
    pending_q.push_back(b);
    // Tiny determinant: huge lateral and depth before saturation.
    b = '{24'hF00000, 24'h0F0000, 24'h010000, 24'hFF0000, 16'sh0001, 16'sh0001,
          16'sh0001, 16'sh0000};
    pending_q.push_back(b);
    repeat (8) pending_q.push_back(scene_beat());
  endtask

  task automatic run_phase(logic [31:0] w, logic [31:0] h, logic [31:0] s, bit directed);
    int n;
    // Let the back end drain before touching the registers.
    wait (pending_q.size() == 0 && !in_valid && projection_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_SCREEN_WIDTH, w);
    reg_write(REG_SCREEN_HEIGHT, h);
    reg_write(REG_HEIGHT_SCALE, s);
    steady = ($urandom_range(0, 3) == 0);
    n = PHASE_ITEMS;
    if (directed) begin
      queue_directed();
      n = n - pending_q.size();
    end
    repeat (n) begin
      if ($urandom_range(0, 99) < 75) pending_q.push_back(scene_beat());
      else pending_q.push_back(noise_beat());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    width_q = 13'd640;
    height_q = 13'd480;
    scale_q = 16'd256;
    errors = 0;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    invalid_seen = 0;
    idle_cycles = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Reset values first, then extremes, out-of-range sizes and ordinary screens.
    run_phase(640, 480, 256, 1'b1);
    run_phase(1, 1, 0, 1'b1);
    run_phase(4096, 4096, 65535, 1'b0);
    run_phase(0, 0, 1, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 128, 1'b0);
    run_phase(320, 200, 512, 1'b0);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 65535),
              1'b0);
    wait (pending_q.size() == 0 && !in_valid && projection_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d sprite beats in, %0d results out (%0d flagged invalid)",
             beats_in, beats_out, invalid_seen);
    $display("seven register settings including zero, maximum and out-of-range sizes");
    if (errors == 0 && projection_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
